// ----- hw/rtl/mat4_column_transform_macros.svh -----
// Assertion helpers shared by the RTL of the column transform block.
// Each helper samples on the rising edge of i_clk and is switched off while
// i_rst_n is low.
`ifndef MAT4_COLUMN_TRANSFORM_MACROS_SVH
`define MAT4_COLUMN_TRANSFORM_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define M4CT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("m4ct: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define M4CT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("m4ct: next-cycle check failed");

`endif

// ----- hw/rtl/m4ct_pkg.sv -----
package m4ct_pkg;

    // Fixed-point format and saturation width.
    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;

    // Vector and matrix geometry.
    localparam int LANES      = 4;
    localparam int LANE_IDX_W = $clog2(LANES);
    localparam int IN_W       = 32;
    localparam int COL_W      = LANES * IN_W;

    // Datapath widths: exact product, shifted term, sum of four terms.
    localparam int PROD_W = 2 * IN_W;
    localparam int TERM_W = PROD_W - FRAC_BITS;
    localparam int ACC_W  = TERM_W + LANE_IDX_W;
    localparam int SAT_W  = 67;

    // Saturation bounds for a WORD_BITS signed word.
    localparam logic signed [SAT_W-1:0] SAT_MAX =
        (SAT_W'(1) << (WORD_BITS - 1)) - SAT_W'(1);
    localparam logic signed [SAT_W-1:0] SAT_MIN = ~SAT_MAX;

    // Stream packing.
    localparam int S_TDATA_W  = 136;
    localparam int TD_COL_LSB = 0;
    localparam int TD_VEC_LSB = TD_COL_LSB + LANE_IDX_W;
    localparam int M_TDATA_W  = COL_W;

    // Command codes carried in the slave tuser.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_XFORM = 1'b1;

    // Number of transform results that may be outstanding.
    localparam int CREDITS   = 2;
    localparam int CREDIT_W  = $clog2(CREDITS + 1);

    typedef logic signed [IN_W-1:0] t_lane;

    typedef struct packed {
        logic             sat;
        logic [COL_W-1:0] data;
    } t_result;

endpackage

// ----- hw/rtl/mat4_column_transform.sv -----
// Column transform: a 4x4 Q16.16 matrix times a 4-vector.
// Slave stream requests: tuser is the command (load a column or transform),
// tdata carries column_index and the four components x, y, z, w.
// A load request writes one matrix column in the cycle it is accepted and
// gives no result. A transform request gives one result on the master stream:
// tdata holds out_x..out_w, tuser flags that some component was clamped.
// Each transform reads one column per cycle from the column memory, so a
// transform occupies the sequencer until all four columns are read; a load
// does not occupy it. A new request can be accepted during the last column
// read. Each result passes the steps read, multiply, accumulate, saturate.
// Up to two transform results may be outstanding; the output holds a result
// register and a skid register, so the pipeline never stalls. When the
// receiver stalls, new requests are refused once two results are outstanding.
// Reset clears the matrix to zero at once through per-column valid bits,
// empties the pipeline and drops any waiting results; no clearing pass.
`include "mat4_column_transform_macros.svh"

module mat4_column_transform (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [1:0] column_index, [33:2] vec_x, [65:34] vec_y, [97:66] vec_z,
    // [129:98] vec_w, [135:130] zero
    input  logic [m4ct_pkg::S_TDATA_W-1:0] i_s_tdata,
    // [0] cmd
    input  logic                           i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [31:0] out_x, [63:32] out_y, [95:64] out_z, [127:96] out_w
    output logic [m4ct_pkg::M_TDATA_W-1:0] o_m_tdata,
    // [0] saturated
    output logic                           o_m_tuser
);

    localparam logic [m4ct_pkg::LANE_IDX_W-1:0] LAST_STEP =
        m4ct_pkg::LANE_IDX_W'(m4ct_pkg::LANES - 1);

    // Sequencer and request registers.
    logic                               r_busy, n_busy;
    logic [m4ct_pkg::LANE_IDX_W-1:0]    r_step, n_step;
    m4ct_pkg::t_lane                    r_vec [m4ct_pkg::LANES];
    logic [m4ct_pkg::CREDIT_W-1:0]      r_credits, n_credits;

    // Column memory and its valid bits.
    logic [m4ct_pkg::COL_W-1:0]         mem [m4ct_pkg::LANES];
    logic [m4ct_pkg::LANES-1:0]         r_col_vld;

    // Pipeline registers.
    logic [m4ct_pkg::COL_W-1:0]         r_rd_data;
    logic                               r_s1_vld;
    logic                               r_s1_keep;
    logic [m4ct_pkg::LANE_IDX_W-1:0]    r_s1_step;
    m4ct_pkg::t_lane                    r_s1_comp;
    logic signed [m4ct_pkg::PROD_W-1:0] r_prod [m4ct_pkg::LANES];
    logic                               r_s2_vld;
    logic [m4ct_pkg::LANE_IDX_W-1:0]    r_s2_step;
    logic signed [m4ct_pkg::ACC_W-1:0]  r_acc [m4ct_pkg::LANES];
    logic                               r_s3_done;

    // Output and skid registers.
    m4ct_pkg::t_result                  r_out, r_skid, res;
    logic                               r_out_vld, r_skid_vld;

    logic s_fire, load_fire, xform_fire, out_fire, credit_ok;

    // Handshakes.
    assign out_fire   = r_out_vld && i_m_tready;
    assign credit_ok  = (r_credits < m4ct_pkg::CREDIT_W'(m4ct_pkg::CREDITS)) || out_fire;
    assign o_s_tready = (!r_busy || (r_step == LAST_STEP)) && credit_ok;
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign load_fire  = s_fire && (i_s_tuser == m4ct_pkg::CMD_LOAD);
    assign xform_fire = s_fire && (i_s_tuser == m4ct_pkg::CMD_XFORM);

    // Next sequencer state and outstanding result count.
    always_comb begin
        n_busy    = r_busy && (r_step != LAST_STEP);
        n_step    = r_busy ? r_step + 1'b1 : r_step;
        if (xform_fire) begin
            n_busy = 1'b1;
            n_step = '0;
        end
        n_credits = r_credits;
        if (xform_fire && !out_fire) begin
            n_credits = r_credits + 1'b1;
        end else if (!xform_fire && out_fire) begin
            n_credits = r_credits - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_step    <= '0;
            r_credits <= '0;
            r_col_vld <= '0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_done <= 1'b0;
        end else begin
            r_busy    <= n_busy;
            r_step    <= n_step;
            r_credits <= n_credits;
            if (load_fire) begin
                r_col_vld[i_s_tdata[m4ct_pkg::TD_COL_LSB +: m4ct_pkg::LANE_IDX_W]] <= 1'b1;
            end
            r_s1_vld  <= r_busy;
            r_s2_vld  <= r_s1_vld;
            r_s3_done <= r_s2_vld && (r_s2_step == LAST_STEP);
        end
    end

    // Latch the vector of an accepted transform.
    always_ff @(posedge i_clk) begin
        if (xform_fire) begin
            for (int l = 0; l < m4ct_pkg::LANES; l++) begin
                r_vec[l] <= i_s_tdata[m4ct_pkg::TD_VEC_LSB + l*m4ct_pkg::IN_W +: m4ct_pkg::IN_W];
            end
        end
    end

    // Column memory: write on load, read one column per busy cycle.
    // A load accepted on the last read cycle writes after that read, which
    // keeps request order.
    always_ff @(posedge i_clk) begin
        if (load_fire) begin
            mem[i_s_tdata[m4ct_pkg::TD_COL_LSB +: m4ct_pkg::LANE_IDX_W]] <=
                i_s_tdata[m4ct_pkg::TD_VEC_LSB +: m4ct_pkg::COL_W];
        end
        r_rd_data <= mem[r_step];
    end

    // Stage 1 side band: vector component and column valid bit.
    always_ff @(posedge i_clk) begin
        r_s1_keep <= r_col_vld[r_step];
        r_s1_step <= r_step;
        r_s1_comp <= r_vec[r_step];
    end

    // Stage 2: four exact products; an unwritten column reads as zero.
    always_ff @(posedge i_clk) begin
        m4ct_pkg::t_lane lane;
        for (int l = 0; l < m4ct_pkg::LANES; l++) begin
            lane = r_s1_keep ? r_rd_data[l*m4ct_pkg::IN_W +: m4ct_pkg::IN_W] : '0;
            r_prod[l] <= lane * r_s1_comp;
        end
        r_s2_step <= r_s1_step;
    end

    // Stage 3: truncate each product and accumulate over the four columns.
    always_ff @(posedge i_clk) begin
        logic signed [m4ct_pkg::TERM_W-1:0] term;
        if (r_s2_vld) begin
            for (int l = 0; l < m4ct_pkg::LANES; l++) begin
                term = m4ct_pkg::TERM_W'(r_prod[l] >>> m4ct_pkg::FRAC_BITS);
                if (r_s2_step == '0) begin
                    r_acc[l] <= m4ct_pkg::ACC_W'(term);
                end else begin
                    r_acc[l] <= r_acc[l] + m4ct_pkg::ACC_W'(term);
                end
            end
        end
    end

    // Saturate the finished sums.
    always_comb begin
        logic signed [m4ct_pkg::SAT_W-1:0] s;
        res.sat  = 1'b0;
        res.data = '0;
        for (int l = 0; l < m4ct_pkg::LANES; l++) begin
            s = m4ct_pkg::SAT_W'(r_acc[l]);
            if (s > m4ct_pkg::SAT_MAX) begin
                s       = m4ct_pkg::SAT_MAX;
                res.sat = 1'b1;
            end else if (s < m4ct_pkg::SAT_MIN) begin
                s       = m4ct_pkg::SAT_MIN;
                res.sat = 1'b1;
            end
            res.data[l*m4ct_pkg::IN_W +: m4ct_pkg::IN_W] = s[m4ct_pkg::IN_W-1:0];
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_fire || !r_out_vld) begin
            if (r_skid_vld) begin
                r_out     <= r_skid;
                r_out_vld <= 1'b1;
                if (r_s3_done) begin
                    r_skid <= res;
                end else begin
                    r_skid_vld <= 1'b0;
                end
            end else if (r_s3_done) begin
                r_out     <= res;
                r_out_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b0;
            end
        end else if (r_s3_done) begin
            r_skid     <= res;
            r_skid_vld <= 1'b1;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out.data;
    assign o_m_tuser  = r_out.sat;

    // Checks on the sequencer, the credit count and the output buffer.
    `M4CT_ASSERT_SAME(a_credit_bound, 1'b1,
        r_credits <= m4ct_pkg::CREDIT_W'(m4ct_pkg::CREDITS))
    `M4CT_ASSERT_SAME(a_room_for_result, r_s3_done && r_skid_vld, out_fire)
    `M4CT_ASSERT_SAME(a_skid_behind_out, r_skid_vld, r_out_vld)
    `M4CT_ASSERT_NEXT(a_xform_starts, xform_fire, r_busy && (r_step == '0))

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

// Scoreboard for the column transform: keeps its own copy of the matrix,
// works out the expected result of every transform request and compares
// each result from the block with the oldest one still awaited.
class xform_scoreboard;

    m4ct_pkg::t_lane   matrix_cols [16];
    m4ct_pkg::t_result awaited [$];
    int unsigned       failures;

    function new();
        foreach (matrix_cols[i]) matrix_cols[i] = '0;
        failures = 0;
    endfunction

    // An accepted request either rewrites one column or adds an awaited result.
    function void note_request(logic cmd, logic [1:0] col, logic [m4ct_pkg::COL_W-1:0] vec);
        m4ct_pkg::t_result res;
        m4ct_pkg::t_lane   comp;
        longint            acc;
        longint            hi_lim;
        longint            lo_lim;
        hi_lim = (longint'(1) << (m4ct_pkg::WORD_BITS - 1)) - 1;
        lo_lim = -hi_lim - 1;
        if (cmd == m4ct_pkg::CMD_LOAD) begin
            for (int r = 0; r < 4; r++) begin
                matrix_cols[col * 4 + r] = vec[r * m4ct_pkg::IN_W +: m4ct_pkg::IN_W];
            end
            return;
        end
        res = '0;
        for (int r = 0; r < 4; r++) begin
            acc = 0;
            // Each product is exact, then floored by the fraction shift.
            for (int c = 0; c < 4; c++) begin
                comp = vec[c * m4ct_pkg::IN_W +: m4ct_pkg::IN_W];
                acc += (longint'(matrix_cols[c * 4 + r]) * longint'(comp))
                       >>> m4ct_pkg::FRAC_BITS;
            end
            // Only the complete sum is clamped.
            if (acc > hi_lim) begin
                acc = hi_lim;
                res.sat = 1'b1;
            end else if (acc < lo_lim) begin
                acc = lo_lim;
                res.sat = 1'b1;
            end
            res.data[r * m4ct_pkg::IN_W +: m4ct_pkg::IN_W] = acc[31:0];
        end
        awaited.push_back(res);
    endfunction

    // A result from the block is matched against the oldest awaited result.
    function void check_result(logic [m4ct_pkg::M_TDATA_W-1:0] data, logic sat);
        m4ct_pkg::t_result exp_res;
        bit                bad;
        if (awaited.size() == 0) begin
            failures++;
            $display("%0t: result with none awaited: expected nothing, actual %h sat=%b",
                     $time, data, sat);
            return;
        end
        exp_res = awaited.pop_front();
        bad = (sat !== exp_res.sat);
        for (int r = 0; r < 4; r++) begin
            if (data[r * m4ct_pkg::IN_W +: m4ct_pkg::IN_W] !==
                exp_res.data[r * m4ct_pkg::IN_W +: m4ct_pkg::IN_W]) begin
                bad = 1'b1;
            end
        end
        if (bad) begin
            failures++;
            $display("%0t: result mismatch: expected w,z,y,x=%h sat=%b, actual %h sat=%b",
                     $time, exp_res.data, exp_res.sat, data, sat);
        end
    endfunction

    function int pending();
        return awaited.size();
    endfunction

endclass

module testbench;

    import m4ct_pkg::*;

    localparam int RANDOM_ITEMS = 2000;
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 24;

    localparam logic [IN_W-1:0] L_MAX  = 32'h7FFF_FFFF;
    localparam logic [IN_W-1:0] L_MIN  = 32'h8000_0000;
    localparam logic [IN_W-1:0] L_ONE  = 32'h0001_0000;
    localparam logic [IN_W-1:0] L_LSBN = 32'hFFFF_FFFF;
    localparam logic [IN_W-1:0] L_ZERO = 32'h0000_0000;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    // [1:0] column_index, [129:2] vec_x..vec_w, [135:130] zero
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;
    // [0] cmd
    logic                 i_s_tuser  = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    // [127:0] out_x..out_w
    logic [M_TDATA_W-1:0] o_m_tdata;
    // [0] saturated
    logic                 o_m_tuser;

    xform_scoreboard board = new();
    bit              calm = 1'b0;
    int unsigned     quiet_cycles = 0;
    int unsigned     items_sent = 0;

    mat4_column_transform u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Gap length: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Four lanes mixing extremes, small Q16.16 values and raw random words.
    function automatic logic [COL_W-1:0] random_vec();
        logic [COL_W-1:0] v;
        logic [IN_W-1:0]  lane;
        int               roll;
        for (int i = 0; i < 4; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 15) begin
                case ($urandom_range(0, 5))
                    0: lane = L_MAX;
                    1: lane = L_MIN;
                    2: lane = L_ZERO;
                    3: lane = L_LSBN;
                    4: lane = L_ONE;
                    default: lane = 32'hFFFF_0000;
                endcase
            end else if (roll < 55) begin
                lane = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            end else begin
                lane = $urandom();
            end
            v[i * IN_W +: IN_W] = lane;
        end
        return v;
    endfunction

    // Present one request and hold it until the block accepts it.
    task automatic send_request(logic cmd, logic [1:0] col, logic [COL_W-1:0] vec);
        int gap;
        if ($urandom_range(0, 199) == 0) calm = ~calm;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {{(S_TDATA_W - TD_VEC_LSB - COL_W){1'b0}}, vec, col};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        items_sent++;
    endtask

    // Receiver: ready for a short run, then a stall unless in a calm stretch.
    initial begin
        int stall;
        forever begin
            i_m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            stall = calm ? 0 : idle_len();
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // Both handshakes are sampled at the edge, before any new drive lands.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                board.note_request(i_s_tuser, i_s_tdata[TD_COL_LSB +: LANE_IDX_W],
                                   i_s_tdata[TD_VEC_LSB +: COL_W]);
            end
            if (o_m_tvalid && i_m_tready) begin
                board.check_result(o_m_tdata, o_m_tuser);
            end
        end
    end

    // Watchdog on cycles in which neither side moves a request or result.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int roll;
        int n;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The matrix is all zeros after reset; the column index is ignored.
        send_request(CMD_XFORM, 2'd3, {L_MIN, L_MAX, L_MIN, L_MAX});

        // Identity matrix passes the vector through unchanged.
        send_request(CMD_LOAD, 2'd0, {L_ZERO, L_ZERO, L_ZERO, L_ONE});
        send_request(CMD_LOAD, 2'd1, {L_ZERO, L_ZERO, L_ONE, L_ZERO});
        send_request(CMD_LOAD, 2'd2, {L_ZERO, L_ONE, L_ZERO, L_ZERO});
        send_request(CMD_LOAD, 2'd3, {L_ONE, L_ZERO, L_ZERO, L_ZERO});
        send_request(CMD_XFORM, 2'd1, {32'h0001_8000, L_LSBN, L_MIN, L_MAX});

        // Row 0 becomes x + y: one step past either bound clamps.
        send_request(CMD_LOAD, 2'd1, {L_ZERO, L_ZERO, L_ONE, L_ONE});
        send_request(CMD_XFORM, 2'd0, {L_ZERO, L_ZERO, 32'h0000_0001, L_MAX});
        send_request(CMD_XFORM, 2'd2, {L_ZERO, L_ZERO, L_LSBN, L_MIN});
        send_request(CMD_XFORM, 2'd0, {L_ZERO, L_ZERO, L_ZERO, L_MAX});

        // Truncation of the products rounds toward minus infinity.
        send_request(CMD_LOAD, 2'd0, {L_MAX, L_MIN, 32'h0000_0001, L_LSBN});
        send_request(CMD_XFORM, 2'd0, {L_ZERO, L_ZERO, L_ZERO, 32'h0000_0001});
        send_request(CMD_XFORM, 2'd0, {L_ZERO, L_ZERO, L_ZERO, L_LSBN});

        // Largest terms of both signs saturate every component.
        for (int c = 0; c < 4; c++) send_request(CMD_LOAD, 2'(c), {4{L_MAX}});
        send_request(CMD_XFORM, 2'd0, {4{L_MAX}});
        send_request(CMD_XFORM, 2'd0, {4{L_MIN}});
        for (int c = 0; c < 4; c++) send_request(CMD_LOAD, 2'(c), {4{L_MIN}});
        send_request(CMD_XFORM, 2'd0, {4{L_MIN}});
        send_request(CMD_XFORM, 2'd3, {L_ONE, L_LSBN, L_ONE, L_LSBN});

        // Random part: whole matrices followed by a batch of vectors, mixed with single random requests.
        while (items_sent < RANDOM_ITEMS + 25) begin
            roll = $urandom_range(0, 99);
            if (roll < 40) begin
                for (int c = 0; c < 4; c++) begin
                    send_request(CMD_LOAD,
                                 ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : 2'(c),
                                 random_vec());
                end
                n = $urandom_range(1, 6);
                repeat (n) send_request(CMD_XFORM, 2'($urandom_range(0, 3)), random_vec());
            end else begin
                send_request((roll < 60) ? CMD_LOAD : CMD_XFORM, 2'($urandom_range(0, 3)),
                             random_vec());
            end
        end
        i_s_tvalid <= 1'b0;

        // Drain the awaited results, then allow for anything stray to appear.
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
